/* rtl/core/mtbc_pkg.sv */
// Shared types and constants of the markup tag balance checker.
`default_nettype none

package mtbc_pkg;

  localparam int unsigned NAME_W         = 64;
  localparam int unsigned LEN_W          = 4;
  localparam int unsigned MAX_NAME_CHARS = 8;
  localparam int unsigned CNT_W          = 6;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_GT    = 8'h3E;

  typedef enum logic [1:0] {
    MODE_OUT,
    MODE_AFTER_LT,
    MODE_NAME
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_MISMATCH     = 3'd1,
    ST_OPEN_LEFT    = 3'd2,
    ST_CLOSE_EMPTY  = 3'd3,
    ST_UNTERMINATED = 3'd4,
    ST_TOO_LONG     = 3'd5,
    ST_OVERFLOW     = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic             balanced;
    logic [2:0]       status;
    logic [CNT_W-1:0] open_count;
  } out_item_t;

  // One stack command from the scanner: a finished tag and/or the end of a text.
  typedef struct packed {
    logic              tag_done;
    logic              closing;
    logic              too_long;
    logic [NAME_W-1:0] name;
    logic [LEN_W-1:0]  len;
    logic              last;
    logic              in_tag;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/markup_tag_balance_checker.sv */
// Top level of the markup tag balance checker: scanner, command queue, stack unit.
//
// The block takes one byte of markup text per cycle and, on the byte marked last, gives
// one result item: balanced, a status code (first error wins) and the stack depth at the
// end, saturated at 63. The scanner classifies each byte in the cycle it is accepted and
// turns each '>' that ends a tag and each last byte into a stack command; a two-entry
// queue hands these to the stack unit, which executes one command per cycle unless a last
// command waits for the output register. Sustained rate is one byte per cycle. Each result
// passes through the queue and is then registered in the output register on out_valid_o.
// The stack keeps its top entry in flops and the rest in a single-port-write RAM of
// STACK_DEPTH entries with registered read, so a pop has its new top ready at once. The
// output register lets the next text stream in while a result waits; the input stalls
// only when the queue is full behind a waiting result. No clearing pass runs after reset.
`default_nettype none

module markup_tag_balance_checker
  import mtbc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  logic q_push_valid, q_push_ready;
  cmd_t q_push_cmd;
  logic q_pop_valid, q_pop_ready;
  cmd_t q_pop_cmd;

  // Classify bytes and collect tag names.
  mtbc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .cmd_valid_o(q_push_valid),
    .cmd_ready_i(q_push_ready),
    .cmd_o      (q_push_cmd)
  );

  // Decouple the scanner from stack stalls.
  mtbc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(q_push_valid),
    .push_ready_o(q_push_ready),
    .push_cmd_i  (q_push_cmd),
    .pop_valid_o (q_pop_valid),
    .pop_ready_i (q_pop_ready),
    .pop_cmd_o   (q_pop_cmd)
  );

  // Execute stack commands and produce the result item.
  mtbc_back #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_pop_valid),
    .cmd_ready_o(q_pop_ready),
    .cmd_i      (q_pop_cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // A balanced text reports status ok and an empty stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.balanced == (out_item_o.status == ST_OK)))
    else $error("balanced flag disagrees with status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.balanced) |-> (out_item_o.open_count == '0))
    else $error("balanced result with tags left open");

  // Open tags left is reported only with a nonempty stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_OPEN_LEFT) |-> (out_item_o.open_count != '0))
    else $error("open-tags status with empty stack");

endmodule

`default_nettype wire

/* rtl/core/mtbc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mtbc_ram #(
  parameter int unsigned WIDTH = 68,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/mtbc_front.sv */
// Byte scanner: tracks tag syntax and collects names into stack commands.
`default_nettype none

module mtbc_front
  import mtbc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          cmd_valid_o,
  input  wire logic     cmd_ready_i,
  output cmd_t          cmd_o
);

  mode_e             mode_q, mode_d;
  logic              closing_q, closing_d;
  logic              too_long_q, too_long_d;
  logic [NAME_W-1:0] name_q, name_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              tag_done;
  logic              accept;

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && cmd_ready_i;

  // Next state of the scanner.
  always_comb begin
    mode_d     = mode_q;
    closing_d  = closing_q;
    too_long_d = too_long_q;
    name_d     = name_q;
    len_d      = len_q;
    tag_done   = 1'b0;
    if (mode_q == MODE_OUT) begin
      if (in_item_i.ch == CH_LT) begin
        mode_d     = MODE_AFTER_LT;
        closing_d  = 1'b0;
        too_long_d = 1'b0;
        name_d     = '0;
        len_d      = '0;
      end
    end else if (in_item_i.ch == CH_GT) begin
      tag_done = 1'b1;
      mode_d   = MODE_OUT;
    end else if (mode_q == MODE_AFTER_LT && in_item_i.ch == CH_SLASH) begin
      closing_d = 1'b1;
      mode_d    = MODE_NAME;
    end else begin
      mode_d = MODE_NAME;
      if (len_q < LEN_W'(MAX_NAME_CHARS)) begin
        for (int i = 0; i < MAX_NAME_CHARS; i++) begin
          if (len_q == LEN_W'(i)) begin
            name_d[8*i +: 8] = in_item_i.ch;
          end
        end
        len_d = len_q + LEN_W'(1);
      end else begin
        too_long_d = 1'b1;
      end
    end
  end

  // Command to the stack side: on a '>' that ends a tag or on the last byte.
  always_comb begin
    cmd_valid_o     = in_valid_i && (tag_done || in_item_i.last);
    cmd_o.tag_done  = tag_done;
    cmd_o.closing   = closing_d;
    cmd_o.too_long  = too_long_d;
    cmd_o.name      = name_d;
    cmd_o.len       = len_d;
    cmd_o.last      = in_item_i.last;
    cmd_o.in_tag    = (mode_d != MODE_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_OUT;
      closing_q  <= 1'b0;
      too_long_q <= 1'b0;
      name_q     <= '0;
      len_q      <= '0;
    end else if (accept) begin
      if (in_item_i.last) begin
        mode_q     <= MODE_OUT;
        closing_q  <= 1'b0;
        too_long_q <= 1'b0;
        name_q     <= '0;
        len_q      <= '0;
      end else begin
        mode_q     <= mode_d;
        closing_q  <= closing_d;
        too_long_q <= too_long_d;
        name_q     <= name_d;
        len_q      <= len_d;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mtbc_queue.sv */
// Two-entry command queue between scanner and stack unit.
`default_nettype none

module mtbc_queue
  import mtbc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire cmd_t push_cmd_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cmd_t      pop_cmd_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            entry_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CW'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mtbc_back.sv */
// Stack unit: executes push/pop commands, keeps the first error, builds results.
`default_nettype none

module mtbc_back
  import mtbc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  output logic      cmd_ready_o,
  input  wire cmd_t cmd_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ENT_W = NAME_W + LEN_W;

  logic [SP_W-1:0]   sp_q, sp_n, sp_d;
  status_e           err_q, err_a, err_b, status;
  logic [NAME_W-1:0] top_name_q;
  logic [LEN_W-1:0]  top_len_q;
  logic              push, pop, fire, out_free;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [ENT_W-1:0]  wdata, rdata, below;
  logic              fwd_q;
  logic [ENT_W-1:0]  fwd_data_q;
  logic              out_valid_q;
  out_item_t         out_q;
  logic [31:0]       sp_ext;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = !cmd_i.last || out_free;
  assign fire        = cmd_valid_i && cmd_ready_o;

  // Apply the command to the stack; keep only the first error.
  always_comb begin
    err_a = err_q;
    if (cmd_i.too_long && err_a == ST_OK) begin
      err_a = ST_TOO_LONG;
    end
    err_b = err_a;
    sp_n  = sp_q;
    push  = 1'b0;
    pop   = 1'b0;
    if (cmd_i.tag_done && err_a == ST_OK) begin
      if (cmd_i.closing) begin
        if (sp_q == '0) begin
          err_b = ST_CLOSE_EMPTY;
        end else if (top_len_q == cmd_i.len && top_name_q == cmd_i.name) begin
          pop  = 1'b1;
          sp_n = sp_q - SP_W'(1);
        end else begin
          err_b = ST_MISMATCH;
        end
      end else begin
        if (sp_q == SP_W'(STACK_DEPTH)) begin
          err_b = ST_OVERFLOW;
        end else begin
          push = 1'b1;
          sp_n = sp_q + SP_W'(1);
        end
      end
    end
    status = err_b;
    if (status == ST_OK && cmd_i.in_tag) begin
      status = ST_UNTERMINATED;
    end
    if (status == ST_OK && sp_n != '0) begin
      status = ST_OPEN_LEFT;
    end
  end

  // Spill the cached top into RAM on a push onto a nonempty stack; keep reading the entry below the top.
  always_comb begin
    sp_d  = fire ? (cmd_i.last ? '0 : sp_n) : sp_q;
    we    = fire && push && (sp_q != '0);
    waddr = AW'(sp_q - SP_W'(1));
    wdata = {top_name_q, top_len_q};
    raddr = (sp_d >= SP_W'(2)) ? AW'(sp_d - SP_W'(2)) : '0;
    below = fwd_q ? fwd_data_q : rdata;
    sp_ext = 32'(sp_n);
  end

  mtbc_ram #(
    .WIDTH(ENT_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wdata;
    if (fire && push) begin
      top_name_q <= cmd_i.name;
      top_len_q  <= cmd_i.len;
    end else if (fire && pop) begin
      top_name_q <= below[ENT_W-1:LEN_W];
      top_len_q  <= below[LEN_W-1:0];
    end
    if (fire && cmd_i.last) begin
      out_q.balanced   <= (status == ST_OK);
      out_q.status     <= status;
      out_q.open_count <= (sp_ext > 32'd63) ? CNT_W'(63) : sp_ext[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      err_q       <= ST_OK;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sp_q  <= sp_d;
      fwd_q <= we && (waddr == raddr);
      if (fire) begin
        err_q <= cmd_i.last ? ST_OK : err_b;
      end
      if (fire && cmd_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire
